>>> hdl/sbpd_pkg.sv
// Package for the sync byte packet deframer.
// Holds default parameter values, reset values and the register map.
// No dependencies.
package sbpd_pkg;

  localparam int unsigned DEF_PAYLOAD_BYTES = 16;
  localparam int unsigned DEF_TYPE_COUNT    = 8;

  localparam logic [7:0] SYNC_BYTE_RESET = 8'h5A;

  localparam int unsigned ADDR_W = 3;

  // register word index (paddr[2])
  localparam logic REG_SYNC = 1'b0;

endpackage

>>> hdl/sync_byte_packet_deframer.sv
// Sync byte packet deframer: hunts for the sync byte, checks the type byte,
// buffers a fixed-length payload in a small RAM and drains it as words.
// Depends on sbpd_pkg.
//
//   port group         dir   handshake          payload
//   in                 in    in_valid/in_stall  rx_byte
//   out                out   out_valid/out_stall pkt_type, payload_byte, byte_index,
//                                               last_byte, header_errors, type_errors
//   cfg                in    APB psel/penable   sync_byte at byte address 0
//
// Each input word is taken in one cycle while framing. After the last payload
// byte the block drains PAYLOAD_BYTES output words through the registered read
// port of the payload RAM, reading the next word only once the previous one is
// taken or none is held; in_stall is high from the last payload byte until the
// last word is taken. rst is synchronous and resets control state, counters and
// sync_byte (to SYNC_BYTE_RESET); the payload RAM is not cleared.
module sync_byte_packet_deframer #(
  parameter int unsigned PAYLOAD_BYTES = sbpd_pkg::DEF_PAYLOAD_BYTES,
  parameter int unsigned TYPE_COUNT    = sbpd_pkg::DEF_TYPE_COUNT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  rx_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  pkt_type,
  output logic [7:0]                  payload_byte,
  output logic [3:0]                  byte_index,
  output logic                        last_byte,
  output logic [15:0]                 header_errors,
  output logic [15:0]                 type_errors,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sbpd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int unsigned IW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam logic [IW-1:0] LAST_ADDR = IW'(PAYLOAD_BYTES - 1);

  typedef enum logic [3:0] {
    ST_HUNT  = 4'b0001,
    ST_TYPE  = 4'b0010,
    ST_FILL  = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_t;

  state_t         state;
  logic [7:0]     sync_byte;
  logic [2:0]     held_type;
  logic [IW-1:0]  wr_addr;
  logic [IW-1:0]  rd_addr;
  logic           rd_pend;
  logic [IW-1:0]  out_idx;
  logic [7:0]     rd_data;
  logic [7:0]     mem [PAYLOAD_BYTES];

  logic accept_in;
  logic out_take;
  logic wr_en;
  logic rd_en;
  logic cfg_wr;
  logic type_ok;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready && (paddr[2] == sbpd_pkg::REG_SYNC);
  assign prdata    = (paddr[2] == sbpd_pkg::REG_SYNC) ? {24'd0, sync_byte} : 32'd0;

  assign in_stall  = (state == ST_DRAIN);
  assign accept_in = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;
  assign type_ok   = ({1'b0, rx_byte} < 9'(TYPE_COUNT));
  assign wr_en     = accept_in && (state == ST_FILL);
  assign rd_en     = (state == ST_DRAIN) && !rd_pend &&
                     (!out_valid || (out_take && !last_byte));

  assign payload_byte = rd_data;
  assign byte_index   = 4'(out_idx);

  // payload RAM, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= rx_byte;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte <= sbpd_pkg::SYNC_BYTE_RESET;
    end else if (cfg_wr) begin
      sync_byte <= pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_HUNT;
      held_type     <= 3'd0;
      wr_addr       <= '0;
      rd_addr       <= '0;
      rd_pend       <= 1'b0;
      out_valid     <= 1'b0;
      header_errors <= 16'd0;
      type_errors   <= 16'd0;
    end else begin
      if (out_take) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_HUNT: begin
          if (accept_in) begin
            if (rx_byte == sync_byte) begin
              state <= ST_TYPE;
            end else begin
              header_errors <= header_errors + 16'd1;
            end
          end
        end
        ST_TYPE: begin
          if (accept_in) begin
            if (type_ok) begin
              held_type <= rx_byte[2:0];
              wr_addr   <= '0;
              state     <= ST_FILL;
            end else begin
              type_errors <= type_errors + 16'd1;
              state       <= ST_HUNT;
            end
          end
        end
        ST_FILL: begin
          if (accept_in) begin
            if (wr_addr == LAST_ADDR) begin
              wr_addr <= '0;
              rd_addr <= '0;
              state   <= ST_DRAIN;
            end else begin
              wr_addr <= wr_addr + 1'b1;
            end
          end
        end
        ST_DRAIN: begin
          if (rd_en) begin
            rd_pend   <= 1'b1;
            out_idx   <= rd_addr;
            last_byte <= (rd_addr == LAST_ADDR);
            pkt_type  <= held_type;
            rd_addr   <= (rd_addr == LAST_ADDR) ? '0 : rd_addr + 1'b1;
          end
          if (rd_pend) begin
            rd_pend   <= 1'b0;
            out_valid <= 1'b1;
          end
          // counters ride on the last word, so hold framing until it is taken
          if (out_take && last_byte) begin
            state <= ST_HUNT;
          end
        end
        default: begin
          state <= ST_HUNT;
        end
      endcase
    end
  end

  a_pend_in_drain: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> state == ST_DRAIN)
    else $error("read pending outside drain");

  a_issue_slot_free: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> !out_valid)
    else $error("read issued while output word still held");

  a_fill_to_drain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL && accept_in && wr_addr == LAST_ADDR) |=> state == ST_DRAIN)
    else $error("last payload byte did not start drain");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_byte) |-> byte_index == 4'(PAYLOAD_BYTES - 1))
    else $error("last word carries wrong index");

endmodule

>>> tb/tb.sv
// Self-checking bench for sync_byte_packet_deframer: drives received bytes, predicts
// the deframed payload words in-bench and compares every output word.
// Depends on sbpd_pkg and the deframer RTL.
module tb;

  localparam int PAYLOAD_N = sbpd_pkg::DEF_PAYLOAD_BYTES;
  localparam int TYPE_N    = sbpd_pkg::DEF_TYPE_COUNT;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [2:0]  ptype;
    logic [7:0]  data;
    logic [3:0]  idx;
    logic        last;
    logic [15:0] hdr;
    logic [15:0] terr;
  } out_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] pkt_type;
  logic [7:0] payload_byte;
  logic [3:0] byte_index;
  logic last_byte;
  logic [15:0] header_errors;
  logic [15:0] type_errors;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [sbpd_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  sync_byte_packet_deframer u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .pkt_type(pkt_type), .payload_byte(payload_byte), .byte_index(byte_index),
    .last_byte(last_byte), .header_errors(header_errors), .type_errors(type_errors),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // deframer prediction state
  logic [7:0]  cur_sync = sbpd_pkg::SYNC_BYTE_RESET;
  int          frame_pos = 0;
  logic [2:0]  frame_type = '0;
  logic [7:0]  payload_buf [PAYLOAD_N];
  logic [15:0] hdr_err_cnt = '0;
  logic [15:0] type_err_cnt = '0;
  out_word_t   expected_words [$];

  logic [7:0] tx_body [PAYLOAD_N];
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  logic hold_req = 1'b0;
  int hold_left = 0;
  int bytes_sent = 0;
  int packets_done = 0;
  int words_checked = 0;
  int mismatches = 0;
  int sync_writes = 0;

  task automatic predict_byte(input logic [7:0] b);
    out_word_t w;
    if (frame_pos == 0) begin
      if (b != cur_sync) hdr_err_cnt = hdr_err_cnt + 16'd1;
      else frame_pos = 1;
    end else if (frame_pos == 1) begin
      if (int'(b) >= TYPE_N) begin
        type_err_cnt = type_err_cnt + 16'd1;
        frame_pos = 0;
      end else begin
        frame_type = b[2:0];
        frame_pos = 2;
      end
    end else begin
      payload_buf[frame_pos - 2] = b;
      frame_pos++;
      if (frame_pos == PAYLOAD_N + 2) begin
        frame_pos = 0;
        packets_done++;
        for (int k = 0; k < PAYLOAD_N; k++) begin
          w.ptype = frame_type;
          w.data  = payload_buf[k];
          w.idx   = k[3:0];
          w.last  = (k == PAYLOAD_N - 1);
          w.hdr   = hdr_err_cnt;
          w.terr  = type_err_cnt;
          expected_words.push_back(w);
        end
      end
    end
  endtask

  task automatic check_word();
    out_word_t exp_w;
    if (expected_words.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t unexpected word: type=%0d byte=%02h idx=%0d", $time,
                 pkt_type, payload_byte, byte_index);
    end else begin
      exp_w = expected_words.pop_front();
      words_checked++;
      if (pkt_type !== exp_w.ptype || payload_byte !== exp_w.data ||
          byte_index !== exp_w.idx || last_byte !== exp_w.last ||
          header_errors !== exp_w.hdr || type_errors !== exp_w.terr) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t mismatch exp: type=%0d byte=%02h idx=%0d last=%0b hdr=%0d terr=%0d",
                   $time, exp_w.ptype, exp_w.data, exp_w.idx, exp_w.last, exp_w.hdr,
                   exp_w.terr);
          $display("%0t          got: type=%0d byte=%02h idx=%0d last=%0b hdr=%0d terr=%0d",
                   $time, pkt_type, payload_byte, byte_index, last_byte, header_errors,
                   type_errors);
        end
      end
    end
  endtask

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left <= HOLD_CYCLES;
      hold_req <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) check_word();
    if (rst) out_stall <= 1'b0;
    else if (hold_left != 0) out_stall <= 1'b1;
    else if (rx_quiet) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < 7);
  end

  task automatic send_byte(input logic [7:0] b);
    if (!tx_quiet) begin
      while ($urandom_range(0, 99) < 7) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(b);
    bytes_sent++;
  endtask

  task automatic random_body();
    for (int k = 0; k < PAYLOAD_N; k++)
      tx_body[k] = ($urandom_range(0, 9) == 0) ? cur_sync : 8'($urandom);
  endtask

  task automatic send_frame(input logic [7:0] ptype);
    send_byte(cur_sync);
    send_byte(ptype);
    for (int k = 0; k < PAYLOAD_N; k++) send_byte(tx_body[k]);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_sync_byte(input logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sbpd_pkg::REG_SYNC, 2'b00};
    pwdata <= {24'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    cur_sync = value;
    sync_writes++;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic test_directed();
    logic [7:0] body [PAYLOAD_N] = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h01, 8'h02, 8'h04, 8'h08,
                                    8'h10, 8'h20, 8'h40, 8'h80, 8'hFE, 8'hFD, 8'h5A, 8'h7F};
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(cur_sync);
    send_byte(8'(TYPE_N));
    // bad type equal to sync: dropped, next byte hunts
    send_byte(cur_sync);
    send_byte(cur_sync);
    send_byte(cur_sync);
    send_byte(8'(TYPE_N - 1));
    foreach (body[k]) send_byte(body[k]);
    wait_drained();
  endtask

  task automatic test_sync_extremes();
    set_sync_byte(8'h00);
    send_byte(8'hFF);
    random_body();
    tx_body[0] = 8'h00;
    send_frame(8'h00);
    wait_drained();
    set_sync_byte(8'hFF);
    send_byte(8'h00);
    random_body();
    tx_body[PAYLOAD_N - 1] = 8'hFF;
    send_frame(8'h03);
    wait_drained();
    set_sync_byte(sbpd_pkg::SYNC_BYTE_RESET);
  endtask

  task automatic test_backpressure();
    hold_req <= 1'b1;
    tx_quiet = 1'b1;
    repeat (3) begin
      random_body();
      send_frame(8'($urandom_range(0, TYPE_N - 1)));
    end
    tx_quiet = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int target;
    int pick;
    for (int phase = 0; phase < 4; phase++) begin
      set_sync_byte((phase == 3) ? sbpd_pkg::SYNC_BYTE_RESET : 8'($urandom));
      tx_quiet = (phase == 1);
      rx_quiet = (phase == 1);
      target = bytes_sent + 90;
      while (bytes_sent < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          random_body();
          send_frame(8'($urandom_range(0, TYPE_N - 1)));
        end else if (pick < 85) begin
          send_byte(cur_sync);
          send_byte(8'($urandom_range(TYPE_N, 255)));
        end else begin
          send_byte(8'($urandom));
        end
      end
      wait_drained();
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_sync_extremes();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    repeat (20) @(posedge clk);
    $display("run covered %0d bytes, %0d packets, %0d words checked, %0d sync writes",
             bytes_sent, packets_done, words_checked, sync_writes);
    $display("hunting, bad types, sync changes and a long hold-off; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("PASS sync_byte_packet_deframer");
    end else begin
      $display("FAIL sync_byte_packet_deframer");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout with %0d words outstanding", expected_words.size());
    $display("FAIL sync_byte_packet_deframer");
    $finish;
  end

endmodule
